/* rtl/core/bus_command_supervisor_assert.svh */
// Assertion macros used by the supervisor RTL.
`ifndef BUS_COMMAND_SUPERVISOR_ASSERT_SVH
`define BUS_COMMAND_SUPERVISOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bcs_pkg.sv */
// Shared types, codes and constants of the bus command supervisor.
package bcs_pkg;

    localparam int TIME_W = 32;
    localparam int PERIOD_W = 16;
    localparam int POS_W = 10;
    localparam int CFG_IDX_W = 2;

    localparam logic [2:0] CMD_NOP     = 3'd0;
    localparam logic [2:0] CMD_HOME    = 3'd1;
    localparam logic [2:0] CMD_SETPOS  = 3'd2;
    localparam logic [2:0] CMD_STOP    = 3'd3;
    localparam logic [2:0] CMD_CLEAR   = 3'd4;
    localparam logic [2:0] CMD_ONESHOT = 3'd5;

    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_HOME      = 3'd1;
    localparam logic [2:0] ACT_SETPOS    = 3'd2;
    localparam logic [2:0] ACT_STOP      = 3'd3;
    localparam logic [2:0] ACT_CLEAR     = 3'd4;
    localparam logic [2:0] ACT_COMMFAULT = 3'd5;

    localparam logic FUNC_FRAME = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    localparam logic [POS_W-1:0] PERMILLE_MAX = 10'd1000;

    localparam logic [CFG_IDX_W-1:0] REG_STATUS_PERIOD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIAG_PERIOD      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT_PERIOD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_TIMEOUT  = 2'd3;

    localparam logic [PERIOD_W-1:0] RST_STATUS_PERIOD    = 16'd10;
    localparam logic [PERIOD_W-1:0] RST_DIAG_PERIOD      = 16'd100;
    localparam logic [PERIOD_W-1:0] RST_HEARTBEAT_PERIOD = 16'd100;
    localparam logic [PERIOD_W-1:0] RST_CONTROL_TIMEOUT  = 16'd50;

    typedef struct packed {
        logic [PERIOD_W-1:0] status_period;
        logic [PERIOD_W-1:0] diag_period;
        logic [PERIOD_W-1:0] heartbeat_period;
        logic [PERIOD_W-1:0] control_timeout;
    } t_cfg;

    typedef struct packed {
        logic              func;
        logic [TIME_W-1:0] now_ticks;
        logic [2:0]        command;
        logic [7:0]        sequence_req;
        logic [POS_W-1:0]  goal_permille;
        logic              command_accepted;
        logic              in_motion;
        logic [TIME_W-1:0] fault_word;
        logic [TIME_W-1:0] motor_fault_word;
    } t_item;

    typedef struct packed {
        logic [2:0]       action;
        logic [POS_W-1:0] target_permille;
        logic             send_status;
        logic             send_fault;
        logic             send_diag;
        logic             send_heartbeat;
        logic             was_duplicate;
        logic             control_active;
    } t_result;

endpackage

/* rtl/core/bcs_cfg_regs.sv */
// Configuration register file: periods and control timeout.
module bcs_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [bcs_pkg::CFG_IDX_W-1:0] i_wr_index,
    input  logic [bcs_pkg::PERIOD_W-1:0]  i_wr_data,
    output bcs_pkg::t_cfg                 o_cfg
);

    bcs_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.status_period    <= bcs_pkg::RST_STATUS_PERIOD;
            r_cfg.diag_period      <= bcs_pkg::RST_DIAG_PERIOD;
            r_cfg.heartbeat_period <= bcs_pkg::RST_HEARTBEAT_PERIOD;
            r_cfg.control_timeout  <= bcs_pkg::RST_CONTROL_TIMEOUT;
        end else if (i_wr_en) begin
            case (i_wr_index)
                bcs_pkg::REG_STATUS_PERIOD:    r_cfg.status_period    <= i_wr_data;
                bcs_pkg::REG_DIAG_PERIOD:      r_cfg.diag_period      <= i_wr_data;
                bcs_pkg::REG_HEARTBEAT_PERIOD: r_cfg.heartbeat_period <= i_wr_data;
                bcs_pkg::REG_CONTROL_TIMEOUT:  r_cfg.control_timeout  <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/core/bcs_eval.sv */
// Supervisor state and the single-pass evaluation of one item.
`include "bus_command_supervisor_assert.svh"

module bcs_eval (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  bcs_pkg::t_item   i_item,
    input  bcs_pkg::t_cfg    i_cfg,
    output bcs_pkg::t_result o_res
);

    logic                        r_started, n_started;
    logic [7:0]                  r_last_seq, n_last_seq;
    logic                        r_seq_valid, n_seq_valid;
    logic                        r_remote_active, n_remote_active;
    logic                        r_host_seen, n_host_seen;
    logic                        r_watchdog_latched, n_watchdog_latched;
    logic [bcs_pkg::TIME_W-1:0]  r_last_control_time, n_last_control_time;
    logic [bcs_pkg::TIME_W-1:0]  r_last_status_time, n_last_status_time;
    logic [bcs_pkg::TIME_W-1:0]  r_last_diag_time, n_last_diag_time;
    logic [bcs_pkg::TIME_W-1:0]  r_last_heartbeat_time, n_last_heartbeat_time;
    logic [bcs_pkg::TIME_W-1:0]  r_prev_faults, n_prev_faults;
    logic [bcs_pkg::TIME_W-1:0]  r_prev_motor_faults, n_prev_motor_faults;

    bcs_pkg::t_result res;
    logic             dup;

    function automatic logic elapsed(
        input logic [bcs_pkg::TIME_W-1:0]   now,
        input logic [bcs_pkg::TIME_W-1:0]   then_t,
        input logic [bcs_pkg::PERIOD_W-1:0] period
    );
        logic [bcs_pkg::TIME_W-1:0] diff;
        diff = now - then_t;
        return diff >= {{(bcs_pkg::TIME_W-bcs_pkg::PERIOD_W){1'b0}}, period};
    endfunction

    always_comb begin
        logic [bcs_pkg::TIME_W-1:0] now;
        logic [bcs_pkg::TIME_W-1:0] ctl_t, sts_t, dia_t, hb_t;
        now   = i_item.now_ticks;
        // The first item after reset stamps every timer with its own time.
        ctl_t = r_started ? r_last_control_time   : now;
        sts_t = r_started ? r_last_status_time    : now;
        dia_t = r_started ? r_last_diag_time      : now;
        hb_t  = r_started ? r_last_heartbeat_time : now;

        n_started             = 1'b1;
        n_last_seq            = r_last_seq;
        n_seq_valid           = r_seq_valid;
        n_remote_active       = r_remote_active;
        n_host_seen           = r_host_seen;
        n_watchdog_latched    = r_watchdog_latched;
        n_last_control_time   = ctl_t;
        n_last_status_time    = sts_t;
        n_last_diag_time      = dia_t;
        n_last_heartbeat_time = hb_t;
        n_prev_faults         = r_prev_faults;
        n_prev_motor_faults   = r_prev_motor_faults;

        res                 = '0;
        res.action          = bcs_pkg::ACT_NONE;
        res.send_heartbeat  = !r_started;
        dup                 = 1'b0;

        if (i_item.func == bcs_pkg::FUNC_FRAME) begin
            n_host_seen         = 1'b1;
            n_watchdog_latched  = 1'b0;
            n_last_control_time = now;
            dup = r_seq_valid && (i_item.sequence_req == r_last_seq) &&
                  (i_item.command != bcs_pkg::CMD_NOP) &&
                  (i_item.command != bcs_pkg::CMD_STOP) &&
                  (i_item.command != bcs_pkg::CMD_ONESHOT);
            if (!dup) begin
                if (i_item.command != bcs_pkg::CMD_NOP) begin
                    n_last_seq  = i_item.sequence_req;
                    n_seq_valid = 1'b1;
                end
                case (i_item.command)
                    bcs_pkg::CMD_HOME: begin
                        res.action = bcs_pkg::ACT_HOME;
                        if (i_item.command_accepted) n_remote_active = 1'b1;
                    end
                    bcs_pkg::CMD_SETPOS: begin
                        res.action = bcs_pkg::ACT_SETPOS;
                        res.target_permille =
                            (i_item.goal_permille > bcs_pkg::PERMILLE_MAX) ?
                            bcs_pkg::PERMILLE_MAX : i_item.goal_permille;
                        if (i_item.command_accepted) begin
                            n_remote_active = 1'b1;
                        end else begin
                            res.send_status = 1'b1;
                            res.send_fault  = 1'b1;
                        end
                    end
                    bcs_pkg::CMD_STOP: begin
                        res.action      = bcs_pkg::ACT_STOP;
                        n_remote_active = 1'b0;
                    end
                    bcs_pkg::CMD_CLEAR: begin
                        res.action      = bcs_pkg::ACT_CLEAR;
                        n_remote_active = 1'b0;
                    end
                    bcs_pkg::CMD_ONESHOT: begin
                        res.send_status = 1'b1;
                        res.send_fault  = 1'b1;
                        res.send_diag   = 1'b1;
                    end
                    default: ;
                endcase
            end
        end else begin
            // One-shot motion watchdog: trips once until the next frame.
            if (r_host_seen && r_remote_active && i_item.in_motion &&
                !r_watchdog_latched && elapsed(now, ctl_t, i_cfg.control_timeout)) begin
                res.action         = bcs_pkg::ACT_COMMFAULT;
                n_remote_active    = 1'b0;
                n_watchdog_latched = 1'b1;
            end
            if (elapsed(now, sts_t, i_cfg.status_period)) begin
                res.send_status    = 1'b1;
                n_last_status_time = now;
            end
            if ((i_item.fault_word != r_prev_faults) ||
                (i_item.motor_fault_word != r_prev_motor_faults) ||
                elapsed(now, dia_t, i_cfg.diag_period)) begin
                res.send_fault      = 1'b1;
                res.send_diag       = 1'b1;
                n_prev_faults       = i_item.fault_word;
                n_prev_motor_faults = i_item.motor_fault_word;
                n_last_diag_time    = now;
            end
            if (elapsed(now, hb_t, i_cfg.heartbeat_period)) begin
                res.send_heartbeat    = 1'b1;
                n_last_heartbeat_time = now;
            end
        end

        res.was_duplicate  = dup;
        res.control_active = n_remote_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started             <= 1'b0;
            r_last_seq            <= '0;
            r_seq_valid           <= 1'b0;
            r_remote_active       <= 1'b0;
            r_host_seen           <= 1'b0;
            r_watchdog_latched    <= 1'b0;
            r_last_control_time   <= '0;
            r_last_status_time    <= '0;
            r_last_diag_time      <= '0;
            r_last_heartbeat_time <= '0;
            r_prev_faults         <= '0;
            r_prev_motor_faults   <= '0;
        end else if (i_en) begin
            r_started             <= n_started;
            r_last_seq            <= n_last_seq;
            r_seq_valid           <= n_seq_valid;
            r_remote_active       <= n_remote_active;
            r_host_seen           <= n_host_seen;
            r_watchdog_latched    <= n_watchdog_latched;
            r_last_control_time   <= n_last_control_time;
            r_last_status_time    <= n_last_status_time;
            r_last_diag_time      <= n_last_diag_time;
            r_last_heartbeat_time <= n_last_heartbeat_time;
            r_prev_faults         <= n_prev_faults;
            r_prev_motor_faults   <= n_prev_motor_faults;
        end
    end

    assign o_res = res;

    `BCS_ASSERT_NOW(a_dup_no_action, i_clk, i_rst_n, i_en && dup, res.action == bcs_pkg::ACT_NONE, "duplicate frame produced an action")
    `BCS_ASSERT_NOW(a_trip_releases, i_clk, i_rst_n, i_en && (res.action == bcs_pkg::ACT_COMMFAULT), !res.control_active, "watchdog trip left control active")
    `BCS_ASSERT_NEXT(a_started_sticks, i_clk, i_rst_n, i_en, r_started, "first item did not mark the block started")
    `BCS_ASSERT_NEXT(a_latch_on_trip, i_clk, i_rst_n, !r_watchdog_latched && !(i_en && (res.action == bcs_pkg::ACT_COMMFAULT)), !r_watchdog_latched, "watchdog latch set without a trip")

endmodule

/* rtl/core/bus_command_supervisor.sv */
// Top level of the bus command supervisor: input stage, evaluation, result stage.
//
// The supervisor takes one item per cycle on the input channel: either a decoded
// control frame (func 0) or an end-of-period tick (func 1), and returns exactly one
// result per item, in order. An item is captured in the input register, passes
// through the evaluation logic and lands in the result register once that register
// is free or being drained, and is offered downstream from there. The sustained
// rate is one item per cycle; the result register is the only thing that can hold the
// pipe, and only while the downstream side keeps i_ready low. Frames drop repeated
// sequence numbers (nop, stop and status one-shot are always let through), map
// commands to gripper actions and track the control-active flag. Ticks run the
// one-shot motion watchdog and raise status, fault/diagnostic and heartbeat
// requests when their periods have elapsed on the wrapping 32-bit tick count, or
// when the fault words change. The first item after reset stamps all timers and
// requests a heartbeat. Periods are in ticks and are written through the
// configuration channel (index 0 status, 1 diag, 2 heartbeat, 3 control timeout),
// which is always ready; write them only while the block is idle. A zero period
// makes its request fire on every tick.
module bus_command_supervisor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bcs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bcs_pkg::PERIOD_W-1:0]  i_cfg_data,

    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_func,
    input  logic [bcs_pkg::TIME_W-1:0]    i_now_ticks,
    input  logic [2:0]                    i_command,
    input  logic [7:0]                    i_sequence_req,
    input  logic [bcs_pkg::POS_W-1:0]     i_goal_permille,
    input  logic                          i_command_accepted,
    input  logic                          i_in_motion,
    input  logic [bcs_pkg::TIME_W-1:0]    i_fault_word,
    input  logic [bcs_pkg::TIME_W-1:0]    i_motor_fault_word,

    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [2:0]                    o_action,
    output logic [bcs_pkg::POS_W-1:0]     o_target_permille,
    output logic                          o_send_status,
    output logic                          o_send_fault,
    output logic                          o_send_diag,
    output logic                          o_send_heartbeat,
    output logic                          o_was_duplicate,
    output logic                          o_control_active
);

    bcs_pkg::t_cfg    cfg;
    bcs_pkg::t_item   r_item;
    bcs_pkg::t_result res;
    bcs_pkg::t_result r_res;
    logic             r_in_valid;
    logic             r_out_valid;
    logic             advance;
    logic             in_xfer;

    // Configuration writes never stall.
    assign o_cfg_ready = 1'b1;

    bcs_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Advance the held item whenever the result register is free or being drained.
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign in_xfer = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload of the input stage: capture on transfer, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item.func             <= i_func;
            r_item.now_ticks        <= i_now_ticks;
            r_item.command          <= i_command;
            r_item.sequence_req     <= i_sequence_req;
            r_item.goal_permille    <= i_goal_permille;
            r_item.command_accepted <= i_command_accepted;
            r_item.in_motion        <= i_in_motion;
            r_item.fault_word       <= i_fault_word;
            r_item.motor_fault_word <= i_motor_fault_word;
        end
    end

    // State updates land at the same edge the result is captured.
    bcs_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= res;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_action          = r_res.action;
    assign o_target_permille = r_res.target_permille;
    assign o_send_status     = r_res.send_status;
    assign o_send_fault      = r_res.send_fault;
    assign o_send_diag       = r_res.send_diag;
    assign o_send_heartbeat  = r_res.send_heartbeat;
    assign o_was_duplicate   = r_res.was_duplicate;
    assign o_control_active  = r_res.control_active;

endmodule
